/* design/esm_pkg.sv */
package esm_pkg;

  localparam int MaxPatternBytes = 32;
  // Pattern bytes that have a configuration register behind them.
  localparam int RegBytes        = 32;
  localparam int WordBytes       = 8;
  localparam int PatternWords    = RegBytes / WordBytes;
  localparam int LenW            = $clog2(MaxPatternBytes + 1);
  localparam int CfgLenW         = 6;
  localparam int CfgDataW        = 64;
  localparam int CfgIndexW       = 3;
  localparam int PosW            = 32;
  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};

  typedef enum logic [CfgIndexW-1:0] {
    RegPatternLength = 3'd0,
    RegPatternWord0  = 3'd1,
    RegPatternWord1  = 3'd2,
    RegPatternWord2  = 3'd3,
    RegPatternWord3  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic advance;  // nonzero text byte taken this cycle
    logic clear;    // terminating zero taken this cycle
    logic in_use;   // cell lies within the pattern length
    logic is_last;  // cell holds the final pattern byte
  } cell_ctrl_t;

endpackage

/* design/esm_cell.sv */
module esm_cell import esm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic [7:0] text_byte,
  input  logic [7:0] pattern_byte,
  input  logic       prev_bit,
  output logic       match_bit,
  output logic       last_hit
);

  logic bit_next;

  // The prefix ending at this cell survives if the shorter prefix held one byte ago.
  assign bit_next = prev_bit & ctrl.in_use & (text_byte == pattern_byte);
  assign last_hit = bit_next & ctrl.is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_bit <= 1'b0;
    end else if (ctrl.clear) begin
      match_bit <= 1'b0;
    end else if (ctrl.advance) begin
      match_bit <= bit_next;
    end
  end

endmodule

/* design/exact_substring_match_stream_core.sv */
// A result is registered: it appears in the cycle after its text byte is taken.
// Throughput: one byte per cycle; the compare through the row of match
// cells is combinational and the shift registered. A waiting result holds off input
// only until it is taken, and the next byte enters in that same cycle.
// Reset (rst, synchronous): match cells, byte position and output valid clear;
// pattern length returns to 1 and pattern bytes to zero.
module exact_substring_match_stream_core import esm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           text_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 match_found,
  output logic [PosW-1:0]      match_start,
  output logic                 text_end
);

  logic [CfgLenW-1:0]         pattern_length;
  logic [CfgDataW-1:0]        pattern_words [PatternWords];
  logic [PosW-1:0]            position;
  logic [LenW-1:0]            len_eff;
  logic [CfgLenW:0]           len_wide;
  logic                       in_fire;
  logic                       is_end;
  logic                       found;
  logic [PosW-1:0]            start;
  logic [MaxPatternBytes-1:0] cell_bits;
  logic [MaxPatternBytes-1:0] cell_hits;
  logic [MaxPatternBytes-1:0] cell_last;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign is_end   = (text_byte == 8'd0);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= CfgLenW'(1);
      for (int w = 0; w < PatternWords; w++) begin
        pattern_words[w] <= '0;
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        RegPatternLength: pattern_length <= cfg_data[CfgLenW-1:0];
        RegPatternWord0:  pattern_words[0] <= cfg_data;
        RegPatternWord1:  pattern_words[1] <= cfg_data;
        RegPatternWord2:  pattern_words[2] <= cfg_data;
        RegPatternWord3:  pattern_words[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // A length of zero acts as one; a length above the cell count is clamped.
  assign len_wide = {1'b0, pattern_length};
  always_comb begin
    priority if (pattern_length == '0) begin
      len_eff = LenW'(1);
    end else if (len_wide > (CfgLenW+1)'(MaxPatternBytes)) begin
      len_eff = LenW'(MaxPatternBytes);
    end else begin
      len_eff = LenW'(len_wide);
    end
  end

  for (genvar i = 0; i < MaxPatternBytes; i++) begin : g_cell
    cell_ctrl_t ctrl;
    logic [7:0] pattern_byte;
    logic       prev_bit;

    if (i < RegBytes) begin : g_reg
      assign pattern_byte = pattern_words[i / WordBytes][(i % WordBytes) * 8 +: 8];
    end else begin : g_none
      // No register here; text bytes are nonzero when compared, so this never matches.
      assign pattern_byte = 8'd0;
    end

    if (i == 0) begin : g_head
      assign prev_bit = 1'b1;
    end else begin : g_link
      assign prev_bit = cell_bits[i-1];
    end

    assign cell_last[i]  = (len_eff == LenW'(i + 1));
    assign ctrl.advance  = in_fire && !is_end;
    assign ctrl.clear    = in_fire && is_end;
    assign ctrl.in_use   = (LenW'(i) < len_eff);
    assign ctrl.is_last  = cell_last[i];

    esm_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .text_byte    (text_byte),
      .pattern_byte (pattern_byte),
      .prev_bit     (prev_bit),
      .match_bit    (cell_bits[i]),
      .last_hit     (cell_hits[i])
    );
  end

  assign found = |cell_hits;
  assign start = position - PosW'(len_eff - LenW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (in_fire) begin
      if (is_end) begin
        position <= '0;
      end else if (position != PosMax) begin
        position <= position + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      match_found <= found && !is_end;
      match_start <= (found && !is_end) ? start : '0;
      text_end    <= is_end;
    end
  end

`ifndef NO_ASSERTIONS
  a_last_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(cell_last))
    else $error("pattern end marker is not on exactly one cell");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && is_end |=> position == '0 && cell_bits == '0)
    else $error("end of text did not clear the match state");

  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    in_fire && !is_end && position != PosMax |=> position == $past(position) + PosW'(1))
    else $error("byte position did not advance");

  a_end_no_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && text_end |-> !match_found && match_start == '0)
    else $error("match reported on the terminating byte");

  a_hold_bits: assert property (@(posedge clk) disable iff (rst)
    !in_fire |=> $stable(cell_bits) && $stable(position))
    else $error("match state changed without a transaction");
`endif

endmodule

/* tb/exact_substring_match_stream_core_tb.sv */
`timescale 1ns / 100ps
module exact_substring_match_stream_core_tb;
  import esm_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int RandomBytes = 450;
  localparam int FirstUnusedReg = int'(RegPatternWord3) + 1;
  localparam int MaxPrinted = 100;

  typedef enum int {
    PaceFree,
    PaceSenderIdle,
    PaceReceiverStall,
    PaceBoth
  } pacing_t;

  typedef struct {
    logic            found;
    logic [PosW-1:0] start;
    logic            ended;
  } match_result_t;

  class substring_scoreboard;
    logic [CfgLenW-1:0]         length_reg;
    logic [CfgDataW-1:0]        pattern_words [PatternWords];
    logic [MaxPatternBytes-1:0] partial_bits;
    logic [PosW-1:0]            position;
    match_result_t              expected_matches [$];
    int                         mismatches;

    function new();
      length_reg = 1;
      foreach (pattern_words[i]) pattern_words[i] = '0;
      partial_bits = '0;
      position = '0;
      mismatches = 0;
    endfunction

    function void apply_reg_write(logic [CfgIndexW-1:0] index, logic [CfgDataW-1:0] data);
      if (index == RegPatternLength) begin
        length_reg = data[CfgLenW-1:0];
      end else if (index >= RegPatternWord0 && index <= RegPatternWord3) begin
        pattern_words[index - RegPatternWord0] = data;
      end
    endfunction

    function void note_text_byte(logic [7:0] text);
      match_result_t              r;
      logic [MaxPatternBytes-1:0] equal_bits;
      int                         n;
      int                         i;
      r.found = 1'b0;
      r.start = '0;
      r.ended = 1'b0;
      if (text == 8'h00) begin
        partial_bits = '0;
        position = '0;
        r.ended = 1'b1;
      end else begin
        n = int'(length_reg);
        if (n == 0) n = 1;
        if (n > MaxPatternBytes) n = MaxPatternBytes;
        equal_bits = '0;
        for (i = 0; i < n && i < RegBytes; i++) begin
          if (pattern_words[i / WordBytes][(i % WordBytes) * 8 +: 8] == text) begin
            equal_bits[i] = 1'b1;
          end
        end
        partial_bits = {partial_bits[MaxPatternBytes-2:0], 1'b1} & equal_bits;
        r.found = partial_bits[n-1];
        if (r.found) r.start = position - PosW'(n - 1);
        if (position != PosMax) position = position + 1'b1;
      end
      expected_matches.push_back(r);
    endfunction

    function int pending();
      return expected_matches.size();
    endfunction

    task report_mismatch(string what);
      if (mismatches < MaxPrinted) $display("%0t: mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_match_result(logic found, logic [PosW-1:0] start, logic ended);
      match_result_t e;
      if (expected_matches.size() == 0) begin
        report_mismatch("result with no transaction waiting for it");
        return;
      end
      e = expected_matches.pop_front();
      if (found !== e.found)
        report_mismatch($sformatf("match_found %b, expected %b", found, e.found));
      if (start !== e.start)
        report_mismatch($sformatf("match_start %0d, expected %0d", start, e.start));
      if (ended !== e.ended)
        report_mismatch($sformatf("text_end %b, expected %b", ended, e.ended));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_write;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           text_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic                 match_found;
  logic [PosW-1:0]      match_start;
  logic                 text_end;

  substring_scoreboard scoreboard = new();
  logic [7:0] pattern [RegBytes];
  int         pattern_len = 1;
  logic [7:0] text_q [$];
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         phase_count = 0;
  int         bytes_sent = 0;
  int         cycle_count = 0;

  exact_substring_match_stream_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .text_byte  (text_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .match_found(match_found),
    .match_start(match_start),
    .text_end   (text_end)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      scoreboard.check_match_result(match_found, match_start, text_end);
    end
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic write_cfg(logic [CfgIndexW-1:0] index, logic [CfgDataW-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    scoreboard.apply_reg_write(index, data);
  endtask

  // Writes the length and all four pattern words, then pokes the unused
  // indexes so that any stray write shows up in the text that follows.
  task automatic load_pattern(logic [CfgLenW-1:0] raw_len);
    logic [CfgDataW-1:0] word;
    int                  w;
    int                  b;
    int                  idx;
    word = {$urandom, $urandom};
    word[CfgLenW-1:0] = raw_len;
    write_cfg(RegPatternLength, word);
    for (w = 0; w < PatternWords; w++) begin
      for (b = 0; b < WordBytes; b++) word[b*8 +: 8] = pattern[w * WordBytes + b];
      write_cfg(cfg_reg_t'(int'(RegPatternWord0) + w), word);
    end
    for (idx = FirstUnusedReg; idx < (1 << CfgIndexW); idx++) begin
      write_cfg(CfgIndexW'(idx), {$urandom, $urandom});
    end
    cfg_write <= 1'b0;
    if (raw_len == 0) pattern_len = 1;
    else if (raw_len > MaxPatternBytes) pattern_len = MaxPatternBytes;
    else pattern_len = int'(raw_len);
  endtask

  // Periodic copies make self-overlapping patterns common.
  function automatic void random_pattern(int zero_odds);
    int period;
    int i;
    period = $urandom_range(1, 4);
    for (i = 0; i < RegBytes; i++) begin
      if (zero_odds != 0 && $urandom_range(1, zero_odds) == 1) pattern[i] = 8'h00;
      else if (i >= period && $urandom_range(0, 2) == 0) pattern[i] = pattern[i - period];
      else pattern[i] = 8'($urandom_range(1, 255));
    end
  endfunction

  task automatic send_text_byte(logic [7:0] text);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    text_byte <= text;
    do @(posedge clk); while (!in_ready);
    scoreboard.note_text_byte(text);
    bytes_sent++;
  endtask

  task automatic stream_text();
    case (pacing_t'(phase_count % 4))
      PaceFree:          begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      PaceSenderIdle:    begin send_idle_pct = 80; recv_stall_pct = 0;  end
      PaceReceiverStall: begin send_idle_pct = 0;  recv_stall_pct = 80; end
      default:           begin send_idle_pct = 7;  recv_stall_pct = 7;  end
    endcase
    phase_count++;
    foreach (text_q[i]) send_text_byte(text_q[i]);
    in_valid <= 1'b0;
    text_q.delete();
    while (scoreboard.pending() != 0) @(posedge clk);
  endtask

  task automatic random_phase(int phase);
    logic [CfgLenW-1:0] raw_len;
    int                 target;
    int                 r;
    int                 n;
    int                 i;
    r = $urandom_range(0, 19);
    if (phase == 0) raw_len = 6'd63;
    else if (phase == 1) raw_len = 6'(MaxPatternBytes);
    else if (phase == 2) raw_len = 6'd1;
    else if (r < 12) raw_len = 6'($urandom_range(2, 6));
    else if (r < 16) raw_len = 6'($urandom_range(7, 32));
    else if (r < 17) raw_len = 6'd0;
    else if (r < 18) raw_len = 6'($urandom_range(33, 63));
    else raw_len = 6'd1;
    random_pattern(phase < 3 ? 0 : 25);
    load_pattern(raw_len);
    target = $urandom_range(12, 40) + pattern_len;
    while (text_q.size() < target) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        for (i = 0; i < pattern_len; i++) text_q.push_back(pattern[i]);
      end else if (r < 55) begin
        // A prefix broken off by an arbitrary byte.
        if (pattern_len > 1) begin
          n = $urandom_range(1, pattern_len - 1);
          for (i = 0; i < n; i++) text_q.push_back(pattern[i]);
        end
        text_q.push_back(8'($urandom_range(1, 255)));
      end else if (r < 85) begin
        text_q.push_back(pattern[$urandom_range(0, pattern_len - 1)]);
      end else if (r < 96) begin
        text_q.push_back(8'($urandom_range(1, 255)));
      end else begin
        text_q.push_back(8'h00);
      end
    end
    // Texts left open carry their match state into the next pattern.
    if ($urandom_range(0, 1) == 1) text_q.push_back(8'h00);
    stream_text();
  endtask

  initial begin
    int phase;
    int random_start;
    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= RegPatternLength;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    text_byte <= 8'h00;
    out_ready <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // The reset pattern is a single zero byte, which no text byte can match.
    text_q = '{8'h01, 8'hFF, 8'h80, 8'h00};
    stream_text();

    // A length of zero acts as one.
    random_pattern(0);
    pattern[0] = 8'hFF;
    load_pattern(6'd0);
    text_q = '{8'hFF, 8'hFF, 8'h7F, 8'h00};
    stream_text();

    // Overlapping occurrences are all reported.
    pattern[0] = 8'h61;
    pattern[1] = 8'h62;
    pattern[2] = 8'h61;
    load_pattern(6'd3);
    text_q = '{8'h61, 8'h62, 8'h61, 8'h62, 8'h61, 8'h00};
    stream_text();

    // A pattern change in mid-text keeps the bits earned under the old one.
    load_pattern(6'd2);
    text_q = '{8'h61};
    stream_text();
    pattern[0] = 8'h78;
    load_pattern(6'd2);
    text_q = '{8'h62, 8'h00};
    stream_text();

    // A zero pattern byte can never be matched.
    pattern[0] = 8'h41;
    pattern[1] = 8'h00;
    load_pattern(6'd2);
    text_q = '{8'h41, 8'h00, 8'h41, 8'h00};
    stream_text();

    phase = 0;
    random_start = bytes_sent;
    while (bytes_sent - random_start < RandomBytes) begin
      random_phase(phase);
      phase++;
    end

    repeat (4) @(posedge clk);
    if (scoreboard.mismatches == 0 && scoreboard.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
design/esm_pkg.sv
design/esm_cell.sv
design/exact_substring_match_stream_core.sv
tb/exact_substring_match_stream_core_tb.sv
